// ===== rtl/core/csgl_pkg.sv =====
package csgl_pkg;

  localparam int unsigned CW = 16;
  typedef logic [CW-1:0] color_t;
  typedef color_t [2:0]  rgb_t;

  // pipeline depths of the three sections
  localparam int unsigned LOG_STEPS = 24;
  localparam int unsigned EXP_STEPS = 24;
  localparam int unsigned SAT_LAT   = 4;
  localparam int unsigned GAM_LAT   = LOG_STEPS + EXP_STEPS + 6;
  localparam int unsigned LUM_LAT   = 2;
  localparam int unsigned TOT_LAT   = SAT_LAT + GAM_LAT + LUM_LAT;

  localparam int unsigned PCT_UNITY = 100;
  localparam int unsigned HALF_MAX  = 32767;

  typedef enum logic [1:0] {
    REG_SAT = 2'd0,
    REG_GAM = 2'd1,
    REG_LUM = 2'd2
  } reg_idx_e;

  // reciprocal multipliers: floor(x/d) = (x * MUL) >> SH over the stated range
  localparam int unsigned DIV3_SH   = 20;
  localparam logic [18:0] DIV3_MUL  = 19'(((64'd1 << DIV3_SH) + 64'd2) / 64'd3);
  localparam int unsigned DIV100_SH = 32;
  localparam logic [25:0] DIV100_MUL = 26'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);
  localparam int unsigned DIVG_SH   = 44;
  localparam logic [37:0] DIVG_MUL  = 38'(((64'd1 << DIVG_SH) + 64'd99) / 64'd100);

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bw;
    logic [63:0] rem;
    res = '0;
    bw  = 64'd1 << 62;
    rem = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bw) begin
        rem = rem - (res + bw);
        res = (res >> 1) + bw;
      end else begin
        res = res >> 1;
      end
      bw = bw >> 2;
    end
    return res;
  endfunction

  // 2^(2^-idx) in Q1.30, idx >= 1
  function automatic logic [30:0] root_const(input int unsigned idx);
    logic [63:0] r;
    r = 64'd1 << 31;
    for (int unsigned i = 1; i <= idx; i++) begin
      r = isqrt64(r << 30);
    end
    return r[30:0];
  endfunction

  // log2 in Q4.24, elaboration only
  function automatic logic [27:0] log2q_const(input logic [15:0] c);
    logic [3:0]  n;
    logic [63:0] x;
    logic [23:0] fr;
    n  = '0;
    fr = '0;
    for (int j = 0; j < 15; j++) begin
      if ((c >> (j + 1)) != 16'd0) n = 4'(j + 1);
    end
    x = 64'(c) << (30 - n);
    for (int i = 1; i <= 24; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        fr[24 - i] = 1'b1;
      end
    end
    return {n, fr};
  endfunction

  localparam logic [27:0] LOG2_MAX = log2q_const(16'(HALF_MAX));

endpackage

// ===== rtl/core/csgl_sat.sv =====
module csgl_sat (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [7:0]        sat_i,
  input  csgl_pkg::rgb_t    color_i,
  output logic              valid_o,
  output csgl_pkg::rgb_t    color_o
);

  logic [csgl_pkg::SAT_LAT-1:0] valid_q;
  csgl_pkg::rgb_t c0_q, c1_q, c2_q, res_q;
  logic [17:0] sum_q;
  logic [15:0] gray_q;
  logic [24:0] v_q [3];
  logic [36:0] gprod;
  logic [6:0]  w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[csgl_pkg::SAT_LAT-2:0], valid_i};
    end
  end

  assign gprod = 37'(sum_q) * 37'(csgl_pkg::DIV3_MUL);
  assign w     = (sat_i > 8'(csgl_pkg::PCT_UNITY)) ? '0 : 7'(8'(csgl_pkg::PCT_UNITY) - sat_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_q   <= color_i;
      sum_q  <= 18'(color_i[0]) + 18'(color_i[1]) + 18'(color_i[2]);
      c1_q   <= c0_q;
      gray_q <= gprod[35:20];
      c2_q   <= c1_q;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [50:0] qprod;
    logic [15:0] clamped;
    assign qprod   = 51'(v_q[l]) * 51'(csgl_pkg::DIV100_MUL);
    assign clamped = (qprod[50:48] != 3'd0) ? 16'hFFFF : qprod[47:32];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[l]   <= 25'(c1_q[l]) * 25'(sat_i) + 25'(gray_q) * 25'(w);
        res_q[l] <= (sat_i == 8'(csgl_pkg::PCT_UNITY)) ? c2_q[l] : clamped;
      end
    end
  end

  assign valid_o = valid_q[csgl_pkg::SAT_LAT-1];
  assign color_o = res_q;

endmodule

// ===== rtl/core/csgl_gamma.sv =====
module csgl_gamma (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [8:0]        gam_i,
  input  csgl_pkg::rgb_t    color_i,
  output logic              valid_o,
  output csgl_pkg::rgb_t    color_o
);

  localparam int unsigned LS = csgl_pkg::LOG_STEPS;
  localparam int unsigned ES = csgl_pkg::EXP_STEPS;
  localparam int unsigned GL = csgl_pkg::GAM_LAT;
  localparam int unsigned MPOS = LS + 3;

  logic [GL-1:0]  valid_q;
  csgl_pkg::rgb_t side_q [GL-1];
  csgl_pkg::rgb_t res_q;
  logic           gam_unity;

  assign gam_unity = (gam_i == 9'(csgl_pkg::PCT_UNITY));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[GL-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= color_i;
      for (int i = 1; i < GL - 1; i++) side_q[i] <= side_q[i-1];
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [30:0] x_q  [0:LS];
    logic [23:0] fr_q [0:LS];
    logic [3:0]  n_q  [0:LS];
    logic [36:0] pl_q;
    logic [37:0] hh_q, hl_q, lh_q, ll_q;
    logic [30:0] p_q  [0:ES];
    logic [23:0] h_q  [0:ES-1];
    logic [6:0]  k_q  [0:ES];
    logic        e_q  [0:ES];
    logic [45:0] mul_q;
    logic [7:0]  sh_q;

    // normalise the input to a Q1.30 mantissa
    logic [14:0] c15;
    logic [3:0]  n0;
    logic [45:0] xs;
    logic [30:0] x0;
    always_comb begin
      c15 = color_i[l][14:0];
      n0  = '0;
      for (int j = 0; j < 15; j++) begin
        if (c15[j]) n0 = 4'(j);
      end
      xs = 46'(c15) << (5'd30 - 5'(n0));
      x0 = (c15 == 15'd0) ? 31'h4000_0000 : xs[30:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0]  <= x0;
        fr_q[0] <= '0;
        n_q[0]  <= n0;
      end
    end

    // one squaring per stage, one fraction bit per stage
    for (genvar i = 1; i <= LS; i++) begin : g_log
      logic [61:0] sq;
      logic [31:0] t;
      logic [23:0] fr_d;
      assign sq = 62'(x_q[i-1]) * 62'(x_q[i-1]);
      assign t  = sq[61:30];
      always_comb begin
        fr_d = fr_q[i-1];
        fr_d[LS-i] = t[31];
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          x_q[i]  <= t[31] ? t[31:1] : t[30:0];
          fr_q[i] <= fr_d;
          n_q[i]  <= n_q[i-1];
        end
      end
    end

    logic [27:0] lg;
    logic [75:0] msum;
    logic [30:0] m;
    assign lg   = csgl_pkg::LOG2_MAX - {n_q[LS], fr_q[LS]};
    assign msum = (76'(hh_q) << 38) + (76'(hl_q) << 19) + (76'(lh_q) << 19) + 76'(ll_q);
    assign m    = msum[74:44];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pl_q   <= 37'(lg) * 37'(gam_i);
        hh_q   <= 38'(pl_q[36:19]) * 38'(csgl_pkg::DIVG_MUL[37:19]);
        hl_q   <= 38'(pl_q[36:19]) * 38'(csgl_pkg::DIVG_MUL[18:0]);
        lh_q   <= 38'(pl_q[18:0]) * 38'(csgl_pkg::DIVG_MUL[37:19]);
        ll_q   <= 38'(pl_q[18:0]) * 38'(csgl_pkg::DIVG_MUL[18:0]);
        p_q[0] <= 31'h4000_0000;
        h_q[0] <= 24'(25'h100_0000 - 25'(m[23:0]));
        k_q[0] <= m[30:24];
        e_q[0] <= |m[23:0];
      end
    end

    // exp2 of one minus the fraction: multiply in one root per set bit
    for (genvar j = 1; j <= ES; j++) begin : g_exp
      localparam logic [30:0] ROOT = csgl_pkg::root_const(j);
      logic [61:0] pm;
      assign pm = 62'(p_q[j-1]) * 62'(ROOT);
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          p_q[j] <= h_q[j-1][ES-j] ? pm[60:30] : p_q[j-1];
          k_q[j] <= k_q[j-1];
          e_q[j] <= e_q[j-1];
        end
      end
      if (j < ES) begin : g_h
        always_ff @(posedge clk_i) begin
          if (en_i) h_q[j] <= h_q[j-1];
        end
      end
    end

    logic [45:0]           shr;
    csgl_pkg::color_t      cin;
    csgl_pkg::color_t      res_d;
    assign shr = mul_q >> sh_q;
    assign cin = side_q[GL-2][l];
    always_comb begin
      if (gam_unity || cin[15]) begin
        res_d = cin;
      end else if (cin == '0) begin
        res_d = (gam_i == '0) ? 16'(csgl_pkg::HALF_MAX) : '0;
      end else if (sh_q > 8'd46) begin
        res_d = '0;
      end else begin
        res_d = shr[15:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mul_q    <= 46'(csgl_pkg::HALF_MAX) * 46'(p_q[ES]);
        sh_q     <= 8'd30 + 8'(e_q[ES]) + 8'(k_q[ES]);
        res_q[l] <= res_d;
      end
    end

    a_log_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_q[LS] |-> x_q[LS][30])
      else $error("log mantissa left [1,2)");
    a_exp_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_q[MPOS + ES] |-> p_q[ES][30])
      else $error("power mantissa left [1,2)");
    a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      valid_q[MPOS] |-> (k_q[0] <= 7'd81))
      else $error("scaled log exponent out of range");
  end

  assign valid_o = valid_q[GL-1];
  assign color_o = res_q;

endmodule

// ===== rtl/core/csgl_lum.sv =====
module csgl_lum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [7:0]        lum_i,
  input  csgl_pkg::rgb_t    color_i,
  output logic              valid_o,
  output csgl_pkg::rgb_t    color_o
);

  logic [csgl_pkg::LUM_LAT-1:0] valid_q;
  csgl_pkg::rgb_t c_q, res_q;
  logic [23:0] v_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[csgl_pkg::LUM_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) c_q <= color_i;
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [49:0] qprod;
    logic [15:0] clamped;
    assign qprod   = 50'(v_q[l]) * 50'(csgl_pkg::DIV100_MUL);
    assign clamped = (qprod[49:48] != 2'd0) ? 16'hFFFF : qprod[47:32];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[l]   <= 24'(color_i[l]) * 24'(lum_i);
        res_q[l] <= (lum_i == 8'(csgl_pkg::PCT_UNITY)) ? c_q[l] : clamped;
      end
    end
  end

  assign valid_o = valid_q[csgl_pkg::LUM_LAT-1];
  assign color_o = res_q;

endmodule

// ===== rtl/core/color_saturation_gamma_luma.sv =====
// Each accepted item passes the saturation, gamma and luminance sections
// in that order. Throughput: one item per cycle unless the output stalls.
// Depth is set by the gamma curve: 24 squaring stages for log2 and 24
// root-multiply stages for exp2, one multiplier per stage and lane.
// A stalled output holds the whole pipeline. Reset clears all valid bits
// and sets saturation, gamma and luminance to 100 percent.
module color_saturation_gamma_luma (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [8:0]  cfg_data_i,
  // pixel in
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] alpha_in_i,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  // pixel out
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  alpha_out_o,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o
);

  localparam int unsigned TL = csgl_pkg::TOT_LAT;

  logic [7:0] sat_q, lum_q;
  logic [8:0] gam_q;

  // register writes; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 8'(csgl_pkg::PCT_UNITY);
      gam_q <= 9'(csgl_pkg::PCT_UNITY);
      lum_q <= 8'(csgl_pkg::PCT_UNITY);
    end else if (cfg_we_i) begin
      unique case (csgl_pkg::reg_idx_e'(cfg_idx_i))
        csgl_pkg::REG_SAT: sat_q <= cfg_data_i[7:0];
        csgl_pkg::REG_GAM: gam_q <= cfg_data_i;
        csgl_pkg::REG_LUM: lum_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline advances together unless the result register is
  // full and not being taken
  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  csgl_pkg::rgb_t rgb_in, rgb_sat, rgb_gam, rgb_out;
  logic           v_sat, v_gam;

  assign rgb_in[0] = red_in_i;
  assign rgb_in[1] = green_in_i;
  assign rgb_in[2] = blue_in_i;

  csgl_sat u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (in_valid_i),
    .sat_i   (sat_q),
    .color_i (rgb_in),
    .valid_o (v_sat),
    .color_o (rgb_sat)
  );

  csgl_gamma u_gamma (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_sat),
    .gam_i   (gam_q),
    .color_i (rgb_sat),
    .valid_o (v_gam),
    .color_o (rgb_gam)
  );

  csgl_lum u_lum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (v_gam),
    .lum_i   (lum_q),
    .color_i (rgb_gam),
    .valid_o (out_valid_o),
    .color_o (rgb_out)
  );

  // alpha only needs its top byte; delay it alongside the colours
  logic [7:0] alpha_q [TL];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      alpha_q[0] <= alpha_in_i[15:8];
      for (int i = 1; i < TL; i++) alpha_q[i] <= alpha_q[i-1];
    end
  end

  assign alpha_out_o = alpha_q[TL-1];
  assign red_out_o   = rgb_out[0][15:8];
  assign green_out_o = rgb_out[1][15:8];
  assign blue_out_o  = rgb_out[2][15:8];

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned SETTLE      = csgl_pkg::TOT_LAT + 10;
  localparam logic [1:0]  IDX_SPARE   = 2'd3;   // no register behind this index

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel8_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_idx_i   = '0;
  logic [8:0]  cfg_data_i  = '0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [15:0] alpha_in_i  = '0;
  logic [15:0] red_in_i    = '0;
  logic [15:0] green_in_i  = '0;
  logic [15:0] blue_in_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  alpha_out_o;
  logic [7:0]  red_out_o;
  logic [7:0]  green_out_o;
  logic [7:0]  blue_out_o;

  color_saturation_gamma_luma u_top (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the adjustment registers, updated on every write
  int unsigned sat_pct = csgl_pkg::PCT_UNITY;
  int unsigned gam_pct = csgl_pkg::PCT_UNITY;
  int unsigned lum_pct = csgl_pkg::PCT_UNITY;

  pixel8_t     pending_px[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          steady     = 1'b0;   // when set, neither side idles
  bit          recv_hold  = 1'b0;   // sink free-runs while set

  // Q2.30 roots 2^(2^-i), built once at start
  longint unsigned root_tab[0:24];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned acc, bw;
    acc = 0;
    bw  = 64'd1 << 62;
    while (bw > v) bw = bw >> 2;
    while (bw != 0) begin
      if (v >= acc + bw) begin
        v   = v - (acc + bw);
        acc = (acc >> 1) + bw;
      end else begin
        acc = acc >> 1;
      end
      bw = bw >> 2;
    end
    return acc;
  endfunction

  // log2 in Q8.24: msb position plus 24 fraction bits by repeated squaring
  function automatic longint unsigned log2_q24(int unsigned c);
    int unsigned     n;
    longint unsigned x, fr;
    n  = 0;
    fr = 0;
    while (n < 15 && (c >> (n + 1)) != 0) n++;
    x = longint'(c) << (30 - n);
    for (int i = 1; i <= 24; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x  = x >> 1;
        fr = fr | (64'd1 << (24 - i));
      end
    end
    return (longint'(n) << 24) | fr;
  endfunction

  function automatic int unsigned gamma_curve(int unsigned c, int unsigned gam);
    longint unsigned m, k, p, sh;
    int unsigned     f, h, e;
    if (c > csgl_pkg::HALF_MAX) return c;
    if (c == 0) return (gam == 0) ? csgl_pkg::HALF_MAX : 0;
    m = (log2_q24(csgl_pkg::HALF_MAX) - log2_q24(c)) * gam / 100;
    k = m >> 24;
    f = int'(m & 64'hFF_FFFF);
    p = 64'd1 << 30;
    e = 0;
    if (f != 0) begin
      h = (1 << 24) - f;
      for (int i = 1; i <= 24; i++)
        if ((h >> (24 - i)) & 1) p = (p * root_tab[i]) >> 30;
      e = 1;
    end
    sh = 30 + e + k;
    if (sh > 46) return 0;
    return int'((longint'(csgl_pkg::HALF_MAX) * p) >> sh);
  endfunction

  // Expected 8-bit pixel for one 16-bit input under the current settings
  function automatic pixel8_t adjust_pixel(logic [15:0] a, logic [15:0] r,
                                           logic [15:0] g, logic [15:0] b);
    int unsigned ch[3];
    int unsigned gray, w, v;
    pixel8_t     px;
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    if (sat_pct != csgl_pkg::PCT_UNITY) begin
      gray = (ch[0] + ch[1] + ch[2]) / 3;
      w    = (sat_pct > csgl_pkg::PCT_UNITY) ? 0 : csgl_pkg::PCT_UNITY - sat_pct;
      for (int i = 0; i < 3; i++) begin
        v     = (ch[i] * sat_pct + gray * w) / 100;
        ch[i] = (v > 65535) ? 65535 : v;
      end
    end
    if (gam_pct != csgl_pkg::PCT_UNITY)
      for (int i = 0; i < 3; i++) ch[i] = gamma_curve(ch[i], gam_pct);
    if (lum_pct != csgl_pkg::PCT_UNITY) begin
      for (int i = 0; i < 3; i++) begin
        v     = ch[i] * lum_pct / 100;
        ch[i] = (v > 65535) ? 65535 : v;
      end
    end
    px.alpha = a[15:8];
    px.red   = ch[0][15:8];
    px.green = ch[1][15:8];
    px.blue  = ch[2][15:8];
    return px;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random colour, biased towards the gamma knee and the ends of the range
  function automatic logic [15:0] pick_color();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom_range(0, 64));
      1:       return 16'($urandom_range(32700, 32840));
      2:       return 16'($urandom_range(65470, 65535));
      3:       return 16'($urandom_range(0, 32767));
      default: return 16'($urandom);
    endcase
  endfunction

  // Cycle guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Sink readiness: random stalls, held high while steady or told to hold
  int unsigned ready_run = 0;
  always @(posedge clk_i) begin
    if (steady || recv_hold) begin
      out_ready_i <= 1'b1;
    end else if (ready_run == 0) begin
      if ($urandom_range(0, 9) < 6) begin
        out_ready_i <= 1'b1;
        ready_run   <= $urandom_range(1, 12);
      end else begin
        out_ready_i <= 1'b0;
        ready_run   <= pick_gap() + 1;
      end
    end else begin
      ready_run <= ready_run - 1;
    end
  end

  // Compare each result taken with the oldest expectation
  always @(posedge clk_i) begin
    pixel8_t want, got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{alpha_out_o, red_out_o, green_out_o, blue_out_o};
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel out: %h", got);
      end else begin
        want = pending_px.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected a%h r%h g%h b%h, got a%h r%h g%h b%h",
                     want.alpha, want.red, want.green, want.blue,
                     got.alpha, got.red, got.green, got.blue);
        end
      end
    end
  end

  // Send one item; valid stays high across back-to-back items
  task automatic send_pixel(logic [15:0] a, logic [15:0] r, logic [15:0] g,
                            logic [15:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    alpha_in_i  <= a;
    red_in_i    <= r;
    green_in_i  <= g;
    blue_in_i   <= b;
    do @(posedge clk_i); while (!in_ready_o);
    pending_px.push_back(adjust_pixel(a, r, g, b));
  endtask

  task automatic send_random(int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(16'($urandom), pick_color(), pick_color(), pick_color());
  endtask

  // Drop valid and wait until every pixel in flight has come out
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Register write, only ever issued with the pipeline empty
  task automatic write_reg(logic [1:0] idx, logic [8:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      csgl_pkg::REG_SAT: sat_pct = val[7:0];
      csgl_pkg::REG_GAM: gam_pct = val;
      csgl_pkg::REG_LUM: lum_pct = val[7:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_adjust(int unsigned s, int unsigned gm, int unsigned l);
    drain();
    write_reg(csgl_pkg::REG_SAT, 9'(s));
    write_reg(csgl_pkg::REG_GAM, 9'(gm));
    write_reg(csgl_pkg::REG_LUM, 9'(l));
  endtask

  // Reset values pass colours through; hit the channel extremes
  task automatic test_passthrough();
    send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hAAAA, 16'h5555, 16'h7FFF, 16'h8000);
    send_pixel(16'h5555, 16'hAAAA, 16'h8000, 16'h7FFF);
  endtask

  // Full desaturation, over-saturation with clamp
  task automatic test_saturation();
    set_adjust(0, 100, 100);
    send_pixel(16'h1234, 16'hFFFF, 16'h0000, 16'h8000);
    set_adjust(200, 100, 100);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h4000, 16'h0001);
    send_pixel(16'h0000, 16'h0100, 16'h7FFF, 16'h8001);
  endtask

  // Zero gamma, zero colour, knee at 32767, steepest curve
  task automatic test_gamma();
    set_adjust(100, 0, 100);
    send_pixel(16'h00FF, 16'h0000, 16'h7FFF, 16'h8000);
    send_pixel(16'hFF00, 16'h0001, 16'h4000, 16'hFFFF);
    set_adjust(100, 300, 100);
    send_pixel(16'h8000, 16'h0000, 16'h0001, 16'h7FFF);
    send_pixel(16'h0001, 16'h4000, 16'h7FFE, 16'h8000);
    set_adjust(100, 511, 100);
    send_pixel(16'h7F7F, 16'h0100, 16'h2000, 16'h7000);
  endtask

  // Black-out, brightness clamp, and a write to the spare index
  task automatic test_luminance();
    set_adjust(100, 100, 0);
    send_pixel(16'hFFFF, 16'hFFFF, 16'h8000, 16'h0101);
    set_adjust(100, 100, 200);
    send_pixel(16'h0000, 16'hFFFF, 16'h7FFF, 16'h0101);
    set_adjust(255, 100, 255);
    send_pixel(16'hC3C3, 16'h8000, 16'h0000, 16'hFFFF);
    drain();
    write_reg(IDX_SPARE, 9'h1FF);
    send_pixel(16'h3C3C, 16'h1111, 16'h2222, 16'h3333);
  endtask

  // Random pixels across a sequence of settings, extremes included
  task automatic test_random();
    int unsigned presets[6][3] = '{'{100, 100, 100}, '{0, 0, 0}, '{255, 511, 255},
                                   '{200, 300, 200}, '{50, 220, 150}, '{100, 45, 100}};
    foreach (presets[i]) begin
      set_adjust(presets[i][0], presets[i][1], presets[i][2]);
      send_random(100);
    end
    // a stretch with no idling on either side
    steady = 1'b1;
    send_random(80);
    steady = 1'b0;
    // hold the sender until the pipeline has emptied
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_px.size() != 0) @(posedge clk_i);
    send_random(20);
    for (int i = 0; i < 5; i++) begin
      set_adjust($urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 255));
      send_random(90);
    end
  endtask

  initial begin
    root_tab[0] = 64'd1 << 31;
    for (int i = 1; i <= 24; i++) root_tab[i] = int_sqrt(root_tab[i - 1] << 30);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_saturation();
    test_gamma();
    test_luminance();
    test_random();

    recv_hold = 1'b1;
    drain();
    if (mismatches == 0 && pending_px.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
